// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- sv/rpld_pkg.sv -----
package rpld_pkg;

  localparam int unsigned NumChannels = 3;
  localparam int unsigned ChIdxW      = $clog2(NumChannels);
  localparam int unsigned WidthW      = 12;

  typedef struct packed {
    logic [1:0]  channel;
    logic        level;
    logic [31:0] time_us;
  } in_item_t;

  typedef struct packed {
    logic       onoff;
    logic [7:0] bright_duty;
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
  } out_item_t;

  typedef logic [NumChannels-1:0][WidthW-1:0] widths_t;

  typedef struct packed {
    logic [11:0] on_threshold;
    logic [7:0]  dim_floor;
    logic [11:0] valid_min;
    logic [11:0] valid_max;
    logic [11:0] fallback_width;
  } cfg_t;

  localparam logic [2:0] CfgOnThreshold   = 3'd0;
  localparam logic [2:0] CfgDimFloor      = 3'd1;
  localparam logic [2:0] CfgValidMin      = 3'd2;
  localparam logic [2:0] CfgValidMax      = 3'd3;
  localparam logic [2:0] CfgFallbackWidth = 3'd4;

  localparam logic [11:0] RstOnThreshold   = 12'd1500;
  localparam logic [7:0]  RstDimFloor      = 8'd20;
  localparam logic [11:0] RstValidMin      = 12'd1000;
  localparam logic [11:0] RstValidMax      = 12'd2000;
  localparam logic [11:0] RstFallbackWidth = 12'd1500;
  localparam logic [11:0] RstPulseWidth    = 12'd1500;

  // (w - 1000) clamped to 0..1000
  localparam logic [11:0] WidthBase = 12'd1000;
  localparam logic [11:0] SpanMax   = 12'd1000;

  // *255/1000 == (*51 >> 3) / 25, *360/1000 == (*9) / 25
  localparam logic [15:0] BrightMul  = 16'd51;
  localparam logic [13:0] HueMul     = 14'd9;
  localparam logic [12:0] RecipMul   = 13'd5243;  // ceil(2^17 / 25)
  localparam int unsigned RecipShift = 17;

  localparam logic [8:0] Hue60  = 9'd60;
  localparam logic [8:0] Hue120 = 9'd120;
  localparam logic [8:0] Hue180 = 9'd180;
  localparam logic [8:0] Hue240 = 9'd240;
  localparam logic [8:0] Hue300 = 9'd300;
  localparam logic [8:0] Hue360 = 9'd360;
  localparam logic [9:0] RampMul = 10'd17;        // 255/60 == 17/4

endpackage

// ----- sv/rpld_fifo.sv -----
module rpld_fifo #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/rpld_front.sv -----
module rpld_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  rpld_pkg::in_item_t item_i,
  input  rpld_pkg::cfg_t    cfg_i,
  output rpld_pkg::widths_t widths_o
);
  import rpld_pkg::*;

  logic [31:0]       rise_q [NumChannels];
  widths_t           width_q, width_d;
  logic              ch_ok;
  logic [ChIdxW-1:0] idx;
  logic [31:0]       dt;
  logic              in_win;
  logic [WidthW-1:0] new_w;

  assign ch_ok  = ({30'd0, item_i.channel} < 32'(NumChannels));
  assign idx    = ChIdxW'(item_i.channel);
  assign dt     = item_i.time_us - (ch_ok ? rise_q[idx] : 32'd0);
  assign in_win = (dt >= {20'd0, cfg_i.valid_min}) && (dt <= {20'd0, cfg_i.valid_max});
  assign new_w  = in_win ? dt[WidthW-1:0] : cfg_i.fallback_width;

  always_comb begin
    width_d = width_q;
    if (accept_i && ch_ok && !item_i.level) begin
      width_d[idx] = new_w;
    end
  end

  assign widths_o = width_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        rise_q[i]  <= '0;
        width_q[i] <= RstPulseWidth;
      end
    end else begin
      width_q <= width_d;
      if (accept_i && ch_ok && item_i.level) begin
        rise_q[idx] <= item_i.time_us;
      end
    end
  end

endmodule

// ----- sv/rpld_back.sv -----
module rpld_back #(
  parameter int unsigned OUT_DEPTH = 4,
  localparam int unsigned CntW = $clog2(OUT_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rpld_pkg::widths_t  widths_i,
  input  logic               head_valid_i,
  output logic               head_pop_o,
  input  logic [CntW-1:0]    out_count_i,
  input  rpld_pkg::cfg_t     cfg_i,
  output logic               out_push_o,
  output rpld_pkg::out_item_t out_item_o
);
  import rpld_pkg::*;

  // stage 1: clamp and small constant products
  logic        s1_v_q;
  logic        s1_onoff_q;
  logic [12:0] s1_b_q;
  logic [13:0] s1_h_q;
  // stage 2: reciprocal products
  logic        s2_v_q;
  logic        s2_onoff_q;
  logic [7:0]  s2_b_q;
  logic [8:0]  s2_h_q;

  logic [CntW:0]  used;
  logic           issue;
  logic [11:0]    w1_d, w2_d;
  logic [9:0]     b_span, h_span;
  logic [15:0]    b_prod;
  logic [13:0]    h_prod;
  logic [25:0]    b_full;
  logic [26:0]    h_full;

  assign used  = (CntW + 1)'(out_count_i) + (CntW + 1)'(s1_v_q) + (CntW + 1)'(s2_v_q);
  assign issue = head_valid_i && (used < (CntW + 1)'(OUT_DEPTH));
  assign head_pop_o = issue;

  assign w1_d   = (widths_i[1] > WidthBase) ? widths_i[1] - WidthBase : 12'd0;
  assign w2_d   = (widths_i[2] > WidthBase) ? widths_i[2] - WidthBase : 12'd0;
  assign b_span = (w1_d > SpanMax) ? SpanMax[9:0] : w1_d[9:0];
  assign h_span = (w2_d > SpanMax) ? SpanMax[9:0] : w2_d[9:0];
  assign b_prod = 16'(b_span) * BrightMul;
  assign h_prod = 14'(h_span) * HueMul;

  assign b_full = 26'(s1_b_q) * 26'(RecipMul);
  assign h_full = 27'(s1_h_q) * 27'(RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_onoff_q <= (widths_i[0] > cfg_i.on_threshold);
      s1_b_q     <= b_prod[15:3];
      s1_h_q     <= h_prod;
    end
    if (s1_v_q) begin
      s2_onoff_q <= s1_onoff_q;
      s2_b_q     <= b_full[RecipShift +: 8];
      s2_h_q     <= h_full[RecipShift +: 9];
    end
  end

  // stage 3: floor, hue sector and ramp
  logic [8:0] q9;
  logic [6:0] q;
  logic [5:0] q_dev;
  logic [5:0] ramp_in;
  logic [9:0] ramp_prod;
  logic [7:0] x, r, g, b;

  always_comb begin
    if (s2_h_q < Hue120) begin
      q9 = s2_h_q;
    end else if (s2_h_q < Hue240) begin
      q9 = s2_h_q - Hue120;
    end else if (s2_h_q < Hue360) begin
      q9 = s2_h_q - Hue240;
    end else begin
      q9 = 9'd0;
    end
  end

  assign q         = q9[6:0];
  assign q_dev     = (q >= Hue60[6:0]) ? 6'(q - Hue60[6:0]) : 6'(Hue60[6:0] - q);
  assign ramp_in   = Hue60[5:0] - q_dev;
  assign ramp_prod = 10'(ramp_in) * RampMul;
  assign x         = ramp_prod[9:2];

  always_comb begin
    if (s2_h_q < Hue60) begin
      r = 8'hFF; g = x;     b = 8'h00;
    end else if (s2_h_q < Hue120) begin
      r = x;     g = 8'hFF; b = 8'h00;
    end else if (s2_h_q < Hue180) begin
      r = 8'h00; g = 8'hFF; b = x;
    end else if (s2_h_q < Hue240) begin
      r = 8'h00; g = x;     b = 8'hFF;
    end else if (s2_h_q < Hue300) begin
      r = x;     g = 8'h00; b = 8'hFF;
    end else begin
      r = 8'hFF; g = 8'h00; b = x;
    end
  end

  assign out_push_o              = s2_v_q;
  assign out_item_o.onoff        = s2_onoff_q;
  assign out_item_o.bright_duty  = (s2_b_q <= cfg_i.dim_floor) ? 8'd0 : s2_b_q;
  assign out_item_o.red_duty     = ~r;
  assign out_item_o.green_duty   = ~g;
  assign out_item_o.blue_duty    = ~b;

endmodule

// ----- sv/rc_pulse_to_led_drive.sv -----
// Decodes RC receiver edge events on three channels into LED drive values. A
// rising edge stores its timestamp; a falling edge measures the pulse width and
// keeps it if inside [valid_min, valid_max], else fallback_width. Each accepted
// event yields exactly one result built from the three stored widths: onoff from
// channel 0, brightness duty from channel 1, inverted RGB duties from channel 2.
// Throughput is one event per cycle: the edge is classified and the width state
// updated at the accepting edge, then the result goes through a three-stage
// mapping pipeline (clamp and scale, reciprocal multiply, hue sector and ramp)
// into the result queue. Only the result queue filling up stalls the pipeline,
// and then the input queue backs up into full. Configuration writes are always
// accepted (ready held high) and must only be issued while the block is idle.
module rc_pulse_to_led_drive #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  rpld_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output rpld_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);
  import rpld_pkg::*;

  localparam int unsigned MidCntW = $clog2(MID_DEPTH + 1);
  localparam int unsigned OutCntW = $clog2(OUT_DEPTH + 1);
  localparam int unsigned WidthsW = $bits(widths_t);
  localparam int unsigned OutW    = $bits(out_item_t);

  cfg_t               cfg_q;
  logic               accept;
  widths_t            front_widths, mid_widths;
  logic [WidthsW-1:0] mid_rdata;
  logic               mid_full, mid_empty, mid_pop;
  logic [MidCntW-1:0] mid_count;
  logic [OutCntW-1:0] out_count;
  logic               out_push, out_full;
  out_item_t          back_item;
  logic [OutW-1:0]    out_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_threshold   <= RstOnThreshold;
      cfg_q.dim_floor      <= RstDimFloor;
      cfg_q.valid_min      <= RstValidMin;
      cfg_q.valid_max      <= RstValidMax;
      cfg_q.fallback_width <= RstFallbackWidth;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgOnThreshold:   cfg_q.on_threshold   <= cfg_data_i;
        CfgDimFloor:      cfg_q.dim_floor      <= cfg_data_i[7:0];
        CfgValidMin:      cfg_q.valid_min      <= cfg_data_i;
        CfgValidMax:      cfg_q.valid_max      <= cfg_data_i;
        CfgFallbackWidth: cfg_q.fallback_width <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;

  rpld_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .cfg_i    (cfg_q),
    .widths_o (front_widths)
  );

  rpld_fifo #(
    .WIDTH (WidthsW),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_widths),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  assign mid_widths = widths_t'(mid_rdata);

  rpld_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .widths_i     (mid_widths),
    .head_valid_i (!mid_empty && (mid_count != '0)),
    .head_pop_o   (mid_pop),
    .out_count_i  (out_count),
    .cfg_i        (cfg_q),
    .out_push_o   (out_push),
    .out_item_o   (back_item)
  );

  rpld_fifo #(
    .WIDTH (OutW),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (back_item),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_item_o = out_item_t'(out_rdata);

  // credit check in the back end keeps the result queue from overflowing
  logic unused_out_full;
  assign unused_out_full = out_full;

endmodule

// ----- sv/rpld_checker.sv -----
`include "assert_macros.svh"

module rpld_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input rpld_pkg::out_item_t out_item_o
);
  import rpld_pkg::*;

  logic [7:0] pending_q;
  logic       in_txn, out_txn;

  assign in_txn  = push && !full;
  assign out_txn = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_txn && !out_txn) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_txn && !in_txn) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> empty, "result queue not empty in reset")
  `ASSERT_CLK(a_no_invented, !empty |-> pending_q != 8'd0, "result without accepted event")
  `ASSERT_CLK(a_hold, (!empty && !pop) |=> (!empty && $stable(out_item_o)), "result changed while waiting")
  `ASSERT_CLK(a_rgb_dominant, !empty |-> (out_item_o.red_duty == 8'd0 || out_item_o.green_duty == 8'd0 || out_item_o.blue_duty == 8'd0), "no dominant color")

endmodule

bind rc_pulse_to_led_drive rpld_checker u_checker (.*);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import rpld_pkg::*;

  localparam logic [1:0] ChanOnOff  = 2'd0;
  localparam logic [1:0] ChanBright = 2'd1;
  localparam logic [1:0] ChanHue    = 2'd2;
  localparam logic [1:0] ChanSpare  = 2'd3;
  localparam logic       LevelFall  = 1'b0;
  localparam logic       LevelRise  = 1'b1;
  localparam logic [2:0] CfgIdxLast = 3'd7;

  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned PhaseCount  = 13;
  localparam int unsigned PhaseEdges  = 48;
  localparam int unsigned DrainCycles = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_item_t    in_item_i;
  logic        empty;
  logic        pop;
  out_item_t   out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  rc_pulse_to_led_drive u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow of the decoder state
  cfg_t        regs_m;
  logic [31:0] rise_m  [NumChannels];
  logic [11:0] width_m [NumChannels];
  out_item_t   drive_q [$];

  bit          idle_on;
  int unsigned fail_cnt;
  int unsigned edge_cnt;
  int unsigned drive_cnt;
  int unsigned reg_cnt;
  int unsigned quiet_cnt;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned scaled_width(logic [11:0] w, int unsigned scale);
    int v;
    v = (int'(w) - int'(WidthBase)) * int'(scale) / int'(SpanMax);
    if (v < 0) v = 0;
    if (v > int'(scale)) v = int'(scale);
    return v;
  endfunction

  function automatic out_item_t drive_from_widths();
    out_item_t   o;
    int unsigned b, h, q, d, x, r, g, bl;
    b = scaled_width(width_m[ChanBright], 255);
    if (b <= regs_m.dim_floor) b = 0;
    h = scaled_width(width_m[ChanHue], 360);
    q = h % Hue120;
    d = (q >= Hue60) ? q - Hue60 : Hue60 - q;
    x = (Hue60 - d) * 255 / Hue60;
    if (h < Hue60) begin
      r = 255; g = x; bl = 0;
    end else if (h < Hue120) begin
      r = x; g = 255; bl = 0;
    end else if (h < Hue180) begin
      r = 0; g = 255; bl = x;
    end else if (h < Hue240) begin
      r = 0; g = x; bl = 255;
    end else if (h < Hue300) begin
      r = x; g = 0; bl = 255;
    end else begin
      r = 255; g = 0; bl = x;
    end
    o.onoff       = width_m[ChanOnOff] > regs_m.on_threshold;
    o.bright_duty = 8'(b);
    o.red_duty    = 8'(255 - r);
    o.green_duty  = 8'(255 - g);
    o.blue_duty   = 8'(255 - bl);
    return o;
  endfunction

  task automatic apply_edge(input in_item_t it);
    logic [31:0] dt;
    if (it.channel < NumChannels) begin
      if (it.level == LevelRise) begin
        rise_m[it.channel] = it.time_us;
      end else begin
        dt = it.time_us - rise_m[it.channel];
        if (dt >= regs_m.valid_min && dt <= regs_m.valid_max) begin
          width_m[it.channel] = dt[11:0];
        end else begin
          width_m[it.channel] = regs_m.fallback_width;
        end
      end
    end
    drive_q.push_back(drive_from_widths());
  endtask

  task automatic reset_shadow();
    regs_m.on_threshold   = RstOnThreshold;
    regs_m.dim_floor      = RstDimFloor;
    regs_m.valid_min      = RstValidMin;
    regs_m.valid_max      = RstValidMax;
    regs_m.fallback_width = RstFallbackWidth;
    for (int i = 0; i < NumChannels; i++) begin
      rise_m[i]  = '0;
      width_m[i] = RstPulseWidth;
    end
  endtask

  task automatic send_edge(input logic [1:0] ch, input logic lvl, input logic [31:0] t);
    in_item_t    it;
    int unsigned gap;
    it.channel = ch;
    it.level   = lvl;
    it.time_us = t;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    apply_edge(it);
    edge_cnt++;
  endtask

  task automatic send_pulse(input logic [1:0] ch, input logic [31:0] t0, input logic [31:0] w);
    send_edge(ch, LevelRise, t0);
    send_edge(ch, LevelFall, t0 + w);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgOnThreshold:   regs_m.on_threshold   = data;
      CfgDimFloor:      regs_m.dim_floor      = data[7:0];
      CfgValidMin:      regs_m.valid_min      = data;
      CfgValidMax:      regs_m.valid_max      = data;
      CfgFallbackWidth: regs_m.fallback_width = data;
      default: ;
    endcase
    reg_cnt++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all_regs(input logic [11:0] thr, input logic [11:0] floor_v,
                                input logic [11:0] vmin, input logic [11:0] vmax,
                                input logic [11:0] fb);
    write_reg(CfgOnThreshold, thr);
    write_reg(CfgDimFloor, floor_v);
    write_reg(CfgValidMin, vmin);
    write_reg(CfgValidMax, vmax);
    write_reg(CfgFallbackWidth, fb);
  endtask

  // Drop push, wait for every outstanding result, then let the pipeline empty.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    idle_on = 1'b1;
    send_edge(ChanSpare, LevelRise, 32'hFFFF_FFFF);
    send_edge(ChanSpare, LevelFall, 32'h0000_0000);
    // fall with no prior rise measures from the zero rise time
    send_edge(ChanOnOff, LevelFall, 32'd1600);
    send_edge(ChanBright, LevelFall, 32'd0);
    send_pulse(ChanBright, 32'hFFFF_FE00, 32'd1792);
    send_pulse(ChanOnOff, 32'h1234_5678, 32'd1500);
    send_pulse(ChanOnOff, 32'h8765_4321, 32'd1501);
    send_pulse(ChanHue, 32'h0000_0000, 32'd1000);
    send_pulse(ChanHue, 32'hFFFF_FFFF, 32'd2000);
    send_pulse(ChanHue, 32'h5555_AAAA, 32'd2001);
    send_pulse(ChanBright, 32'hAAAA_5555, 32'd1078);
    send_pulse(ChanBright, 32'h0F0F_F0F0, 32'd1083);
    settle();
  endtask

  task automatic test_extreme_regs();
    write_all_regs(12'd0, 12'hF00, 12'd0, 12'hFFF, 12'd0);
    send_pulse(ChanBright, 32'h0000_1000, 32'd0);
    send_pulse(ChanHue, 32'hFFFF_F000, 32'd4095);
    send_pulse(ChanOnOff, 32'h7FFF_FFFF, 32'd0);
    settle();
    // empty window: every fall takes the fallback width
    write_all_regs(12'hFFF, 12'hFFF, 12'd2000, 12'd1000, 12'hFFF);
    send_pulse(ChanOnOff, 32'h0000_0001, 32'd1500);
    send_pulse(ChanBright, 32'h8000_0000, 32'd1500);
    settle();
    for (int i = CfgFallbackWidth + 1; i <= CfgIdxLast; i++) begin
      write_reg(3'(i), 12'($urandom_range(0, 4095)));
    end
    send_edge(ChanHue, LevelFall, 32'h0000_0000);
    settle();
  endtask

  task automatic test_random_edges();
    logic [31:0] rise_at [NumChannels];
    bit          armed   [NumChannels];
    logic [1:0]  ch;
    logic [31:0] t, w;
    int unsigned pick;
    logic [11:0] vmin, vmax;
    for (int i = 0; i < NumChannels; i++) armed[i] = 1'b0;
    for (int p = 0; p < PhaseCount; p++) begin
      idle_on = (p % 3) != 2;
      if (p == 0) begin
        write_all_regs(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      end else if (p == 1) begin
        write_all_regs(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      end else begin
        vmin = 12'($urandom_range(0, 1200));
        vmax = 12'($urandom_range(1800, 4095));
        if ($urandom_range(0, 4) == 0) begin
          vmin = 12'($urandom_range(1500, 4095));
          vmax = 12'($urandom_range(0, 1499));
        end
        write_all_regs(12'($urandom_range(900, 2100)), 12'($urandom_range(0, 4095)), vmin, vmax,
                       12'($urandom_range(0, 4095)));
      end
      for (int n = 0; n < PhaseEdges; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_edge(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom());
        end else begin
          ch = 2'($urandom_range(0, NumChannels - 1));
          if (!armed[ch]) begin
            t = $urandom();
            send_edge(ch, LevelRise, t);
            rise_at[ch] = t;
            armed[ch] = 1'b1;
          end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
              w = $urandom_range(800, 2200);
            end else if (pick < 9 && regs_m.valid_min <= regs_m.valid_max) begin
              w = $urandom_range(regs_m.valid_min, regs_m.valid_max);
            end else if (pick < 9) begin
              w = $urandom_range(0, 4095);
            end else begin
              w = $urandom();
            end
            send_edge(ch, LevelFall, rise_at[ch] + w);
            armed[ch] = 1'b0;
          end
        end
      end
      settle();
    end
  endtask

  // Result side: random back-pressure per transaction while idle_on is set
  initial begin
    int unsigned stall;
    pop <= 1'b0;
    wait (rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      drive_cnt++;
      if (drive_q.size() == 0) begin
        $error("drive result with nothing outstanding");
        fail_cnt++;
      end else begin
        want = drive_q.pop_front();
        if (out_item_o.onoff !== want.onoff) begin
          $error("onoff: expected %0d, actual %0d", want.onoff, out_item_o.onoff);
          fail_cnt++;
        end
        if (out_item_o.bright_duty !== want.bright_duty) begin
          $error("bright_duty: expected %0d, actual %0d", want.bright_duty,
                 out_item_o.bright_duty);
          fail_cnt++;
        end
        if (out_item_o.red_duty !== want.red_duty) begin
          $error("red_duty: expected %0d, actual %0d", want.red_duty, out_item_o.red_duty);
          fail_cnt++;
        end
        if (out_item_o.green_duty !== want.green_duty) begin
          $error("green_duty: expected %0d, actual %0d", want.green_duty,
                 out_item_o.green_duty);
          fail_cnt++;
        end
        if (out_item_o.blue_duty !== want.blue_duty) begin
          $error("blue_duty: expected %0d, actual %0d", want.blue_duty, out_item_o.blue_duty);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    idle_on     = 1'b1;
    fail_cnt    = 0;
    edge_cnt    = 0;
    drive_cnt   = 0;
    reg_cnt     = 0;
    quiet_cnt   = 0;
    reset_shadow();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_extreme_regs();
    test_random_edges();

    $display("Covered %0d edge events on all four channel codes, %0d drive results checked,",
             edge_cnt, drive_cnt);
    $display("%0d register writes incl. reserved indexes, empty and full-range windows",
             reg_cnt);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- rc_pulse_to_led_drive.f -----
+incdir+sv
sv/rpld_pkg.sv
sv/rpld_fifo.sv
sv/rpld_front.sv
sv/rpld_back.sv
sv/rc_pulse_to_led_drive.sv
sv/rpld_checker.sv
tb/sv/testbench.sv
